/* rtl/tuas_pkg.sv */
// Shared types and constants for the TOPUS upwind advection step.
// Used by every module under rtl/ except tuas_div; depends on nothing.
package tuas_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 24;
    localparam int FRACTION_BITS_DEF = 20;

    localparam int COURANT_WIDTH = 17;
    localparam int COURANT_FRAC  = 16;
    localparam logic [COURANT_WIDTH-1:0] COURANT_RESET = 17'd3277;
    localparam logic MODE_RESET = 1'b1;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = COURANT_WIDTH;

    // bits of the multiplier operand consumed per cycle
    localparam int MUL_DIGIT = 16;

    // row position codes
    localparam logic [1:0] POS_START  = 2'd0;
    localparam logic [1:0] POS_FIRST  = 2'd1;
    localparam logic [1:0] POS_SECOND = 2'd2;
    localparam logic [1:0] POS_MAX    = 2'd3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COURANT     = 1'b0,
        REG_SCHEME_MODE = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MGO,
        ST_MWAIT,
        ST_POLY,
        ST_EMIT,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        MUL_U2,
        MUL_U3,
        MUL_U4,
        MUL_FACE,
        MUL_FLUX
    } mul_op_t;

    typedef enum logic [1:0] {
        OUT_CENTER,
        OUT_RESULT,
        OUT_INPUT
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        logic     mul_start;
        mul_op_t  mul_op;
        logic     poly_load;
        logic     face_pass;
        logic     out_load;
        out_sel_t out_sel;
        logic     advance;
    } cmd_t;

    typedef struct packed {
        logic [1:0] pos;
        logic       last;
        logic       skip;
        logic       div_valid;
        logic       mul_valid;
        logic       out_free;
    } status_t;

endpackage

/* rtl/tuas_div.sv */
// Restoring divider, one quotient bit per cycle, for the limiter ratio.
// Standalone; needs no package.
module tuas_div #(
    parameter int MAG_WIDTH = 24,
    parameter int QUO_WIDTH = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_WIDTH-1:0] num,
    input  logic [MAG_WIDTH-1:0] den,
    output logic [QUO_WIDTH-1:0] quo,
    output logic                 valid
);

    localparam int CNT_W = $clog2(QUO_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_WIDTH - 1);

    logic                 busy_reg;
    logic                 valid_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MAG_WIDTH:0]   rem_reg;
    logic [MAG_WIDTH-1:0] den_reg;
    logic [QUO_WIDTH-1:0] quo_reg;

    logic [MAG_WIDTH:0]   shifted;
    logic                 ge;

    // first step compares without a shift (integer bit of the ratio)
    always_comb
    begin
        shifted = (cnt_reg == '0) ? rem_reg : {rem_reg[MAG_WIDTH-1:0], 1'b0};
        ge      = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[QUO_WIDTH-2:0], ge};
        end
    end

    assign quo   = quo_reg;
    assign valid = valid_reg;

endmodule

/* rtl/tuas_mul.sv */
// Digit-serial signed-by-unsigned multiplier, MUL_DIGIT bits of b per cycle.
// Depends on tuas_pkg.
module tuas_mul #(
    parameter int A_WIDTH = 25,
    parameter int B_WIDTH = 21
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [A_WIDTH-1:0]           a,
    input  logic [B_WIDTH-1:0]                  b,
    output logic signed [A_WIDTH+B_WIDTH-1:0]   prod,
    output logic                                valid
);
    import tuas_pkg::*;

    localparam int ND    = (B_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BP    = ND * MUL_DIGIT;
    localparam int PW    = A_WIDTH + BP;
    localparam int XW    = A_WIDTH + MUL_DIGIT + 1;
    localparam int CNT_W = (ND > 1) ? $clog2(ND) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ND - 1);

    logic                      busy_reg;
    logic                      valid_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [A_WIDTH-1:0] a_reg;
    logic [BP-1:0]             b_reg;
    logic signed [PW-1:0]      acc_reg;

    logic [MUL_DIGIT-1:0]      digit;
    logic signed [XW-1:0]      a_x;
    logic signed [XW-1:0]      d_x;
    logic signed [XW-1:0]      part;

    // most significant digit first: acc = acc * 2^DIGIT + a * digit
    always_comb
    begin
        digit = b_reg[BP-1 -: MUL_DIGIT];
        a_x   = XW'(a_reg);
        d_x   = XW'({1'b0, digit});
        part  = a_x * d_x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg  <= 1'b0;
                    valid_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= BP'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg <<< MUL_DIGIT) + PW'(part);
            b_reg   <= b_reg << MUL_DIGIT;
        end
    end

    assign prod  = acc_reg[A_WIDTH+B_WIDTH-1:0];
    assign valid = valid_reg;

endmodule

/* rtl/tuas_dp.sv */
// Datapath: row state, config registers, ratio divider, shared multiplier,
// limiter polynomial, saturation and the output register. Uses tuas_pkg,
// tuas_div and tuas_mul.
module tuas_dp #(
    parameter int SAMPLE_WIDTH  = tuas_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = tuas_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tuas_pkg::cmd_t                       cmd,
    output tuas_pkg::status_t                    status,
    input  logic                                 cfg_we,
    input  logic [tuas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tuas_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic [SAMPLE_WIDTH-1:0]              in_sample,
    input  logic                                 in_last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [SAMPLE_WIDTH-1:0]              out_sample,
    output logic                                 out_last
);
    import tuas_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int FB  = FRACTION_BITS;
    localparam int DW  = SW + 1;                 // differences
    localparam int QW  = FB + 1;                 // ratio, powers, f: 0..1
    localparam int AW  = (DW > FB + 2) ? DW : FB + 2;
    localparam int BW  = (QW > COURANT_WIDTH) ? QW : COURANT_WIDTH;
    localparam int PRW = AW + BW;
    localparam int PFW = FB + 4;                 // polynomial before clamp
    localparam int TW  = SW + 3;                 // flux term
    localparam int YW  = SW + 4;                 // result before saturation

    localparam logic signed [YW-1:0]  Y_MAX = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [YW-1:0]  Y_MIN = -Y_MAX - YW'(1);
    localparam logic signed [PFW-1:0] F_ONE = PFW'(1) <<< FB;

    // config
    logic [COURANT_WIDTH-1:0] courant_reg;
    logic                     mode_reg;

    // row state
    logic signed [SW-1:0] sp1_reg;   // centre sample c
    logic signed [SW-1:0] sp2_reg;   // left sample l
    logic signed [SW-1:0] pf_reg;    // previous face value
    logic [1:0]           pos_reg;

    // per-item working registers
    logic signed [SW-1:0] x_reg;
    logic                 last_reg;
    logic signed [DW-1:0] n_reg;     // c - l
    logic signed [DW-1:0] d_reg;     // r - l
    logic [QW-1:0]        u_reg;
    logic [QW-1:0]        pw_reg;    // running power of u
    logic [QW-1:0]        u3_reg;
    logic [QW-1:0]        f_reg;
    logic signed [SW-1:0] uf_reg;
    logic signed [SW-1:0] y_reg;

    // output register
    logic                 out_valid_reg;
    logic [SW-1:0]        out_data_reg;
    logic                 out_last_reg;

    logic                 skip;
    logic                 d_zero;
    logic                 d_neg;
    logic                 n_neg;
    logic signed [DW-1:0] n_abs;
    logic signed [DW-1:0] d_abs;
    logic [QW-1:0]        div_quo;
    logic                 div_valid;

    logic signed [AW-1:0]  mul_a;
    logic [BW-1:0]         mul_b;
    logic signed [PRW-1:0] mul_prod;
    logic                  mul_valid;
    logic signed [DW-1:0]  diff;

    logic signed [PRW-1:0] prod_sh;
    logic signed [PRW-1:0] flux_sh;
    logic signed [DW-1:0]  fd;
    logic signed [DW-1:0]  uf_sum;
    logic signed [TW-1:0]  flux_t;
    logic signed [YW-1:0]  y_full;
    logic signed [SW-1:0]  y_sat;

    logic signed [PFW-1:0] p_u;
    logic signed [PFW-1:0] p_u3;
    logic signed [PFW-1:0] p_u4;
    logic signed [PFW-1:0] f_raw;
    logic [QW-1:0]         f_clamp;

    logic                  out_free;

    // ratio test: face falls back to the centre sample
    always_comb
    begin
        d_zero = (d_reg == '0);
        d_neg  = d_reg[DW-1];
        n_neg  = n_reg[DW-1];
        skip   = d_zero
              || (!d_neg && (n_neg || (n_reg > d_reg)))
              || (d_neg && ((!n_neg && (n_reg != '0)) || (n_reg < d_reg)));
        n_abs  = n_neg ? -n_reg : n_reg;
        d_abs  = d_neg ? -d_reg : d_reg;
    end

    tuas_div #(
        .MAG_WIDTH (SW),
        .QUO_WIDTH (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (n_abs[SW-1:0]),
        .den   (d_abs[SW-1:0]),
        .quo   (div_quo),
        .valid (div_valid)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        if ((pos_reg == POS_SECOND) || !mode_reg)
            diff = n_reg;
        else
            diff = DW'(uf_reg) - DW'(pf_reg);

        unique case (cmd.mul_op)
            MUL_U2:
            begin
                mul_a = AW'(u_reg);
                mul_b = BW'(u_reg);
            end
            MUL_U3, MUL_U4:
            begin
                mul_a = AW'(pw_reg);
                mul_b = BW'(u_reg);
            end
            MUL_FACE:
            begin
                mul_a = AW'(d_reg);
                mul_b = BW'(f_reg);
            end
            MUL_FLUX:
            begin
                mul_a = AW'(diff);
                mul_b = BW'(courant_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tuas_mul #(
        .A_WIDTH (AW),
        .B_WIDTH (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .valid (mul_valid)
    );

    // product post-processing; shifts of the exact product floor the result
    always_comb
    begin
        prod_sh = mul_prod >>> FB;
        flux_sh = mul_prod >>> COURANT_FRAC;
        fd      = prod_sh[DW-1:0];
        uf_sum  = DW'(sp2_reg) + fd;
        flux_t  = flux_sh[TW-1:0];
        y_full  = YW'(sp1_reg) - YW'(flux_t);
        if (y_full > Y_MAX)
            y_sat = Y_MAX[SW-1:0];
        else if (y_full < Y_MIN)
            y_sat = Y_MIN[SW-1:0];
        else
            y_sat = y_full[SW-1:0];
    end

    // f(u) = 2u^4 - 3u^3 + 2u, clamped to 0..1
    always_comb
    begin
        p_u   = PFW'(u_reg);
        p_u3  = PFW'(u3_reg);
        p_u4  = PFW'(pw_reg);
        f_raw = (p_u4 <<< 1) - (p_u3 + (p_u3 <<< 1)) + (p_u <<< 1);
        if (f_raw[PFW-1])
            f_clamp = '0;
        else if (f_raw > F_ONE)
            f_clamp = F_ONE[QW-1:0];
        else
            f_clamp = f_raw[QW-1:0];
    end

    assign out_free = !out_valid_reg || out_ready;

    // config and row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            courant_reg <= COURANT_RESET;
            mode_reg    <= MODE_RESET;
            sp1_reg     <= '0;
            sp2_reg     <= '0;
            pf_reg      <= '0;
            pos_reg     <= POS_START;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COURANT:     courant_reg <= cfg_data[COURANT_WIDTH-1:0];
                    REG_SCHEME_MODE: mode_reg    <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (cmd.advance)
            begin
                if (last_reg)
                begin
                    sp1_reg <= '0;
                    sp2_reg <= '0;
                    pf_reg  <= '0;
                    pos_reg <= POS_START;
                end
                else
                begin
                    sp2_reg <= sp1_reg;
                    sp1_reg <= x_reg;
                    if (pos_reg >= POS_SECOND)
                        pf_reg <= uf_reg;
                    if (pos_reg != POS_MAX)
                        pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= $signed(in_sample);
            last_reg <= in_last;
            n_reg    <= DW'(sp1_reg) - DW'(sp2_reg);
            d_reg    <= DW'($signed(in_sample)) - DW'(sp2_reg);
        end
        if (div_valid)
            u_reg <= div_quo;
        if (cmd.poly_load)
            f_reg <= f_clamp;
        if (cmd.face_pass)
            uf_reg <= sp1_reg;
        if (mul_valid)
        begin
            unique case (cmd.mul_op)
                MUL_U2:   pw_reg <= prod_sh[QW-1:0];
                MUL_U3:
                begin
                    pw_reg <= prod_sh[QW-1:0];
                    u3_reg <= prod_sh[QW-1:0];
                end
                MUL_U4:   pw_reg <= prod_sh[QW-1:0];
                MUL_FACE: uf_reg <= uf_sum[SW-1:0];
                MUL_FLUX: y_reg  <= y_sat;
                default:  ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                OUT_CENTER:
                begin
                    out_data_reg <= sp1_reg;
                    out_last_reg <= 1'b0;
                end
                OUT_RESULT:
                begin
                    out_data_reg <= y_reg;
                    out_last_reg <= 1'b0;
                end
                OUT_INPUT:
                begin
                    out_data_reg <= x_reg;
                    out_last_reg <= 1'b1;
                end
                default:
                begin
                    out_data_reg <= y_reg;
                    out_last_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_data_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        status.pos       = pos_reg;
        status.last      = last_reg;
        status.skip      = skip;
        status.div_valid = div_valid;
        status.mul_valid = mul_valid;
        status.out_free  = out_free;
    end

`ifndef SYNTHESIS
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over an untaken beat");

    a_div_not_skipped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !skip)
        else $error("divider started on a fallback face");

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_valid && mul_valid))
        else $error("divider and multiplier finished together");

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && last_reg) |=> (pos_reg == POS_START))
        else $error("row position not cleared after row end");
`endif

endmodule

/* rtl/tuas_ctrl.sv */
// Controller: sequences capture, ratio divide, multiplies and result beats.
// Depends on tuas_pkg.
module tuas_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tuas_pkg::status_t status,
    output tuas_pkg::cmd_t    cmd
);
    import tuas_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    mul_op_t op_reg;
    mul_op_t op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= MUL_U2;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_op  = op_reg;
        cmd.out_sel = OUT_RESULT;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.pos == POS_START)
                        state_next = ST_FIN;
                    else if (status.pos == POS_FIRST)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.skip)
                begin
                    cmd.face_pass = 1'b1;
                    op_next       = MUL_FLUX;
                    state_next    = ST_MGO;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_valid)
                begin
                    op_next    = MUL_U2;
                    state_next = ST_MGO;
                end
            end
            ST_MGO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_MWAIT;
            end
            ST_MWAIT:
            begin
                if (status.mul_valid)
                begin
                    unique case (op_reg)
                        MUL_U2:
                        begin
                            op_next    = MUL_U3;
                            state_next = ST_MGO;
                        end
                        MUL_U3:
                        begin
                            op_next    = MUL_U4;
                            state_next = ST_MGO;
                        end
                        MUL_U4:   state_next = ST_POLY;
                        MUL_FACE:
                        begin
                            op_next    = MUL_FLUX;
                            state_next = ST_MGO;
                        end
                        MUL_FLUX: state_next = ST_EMIT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POLY:
            begin
                cmd.poly_load = 1'b1;
                op_next       = MUL_FACE;
                state_next    = ST_MGO;
            end
            ST_EMIT:
            begin
                cmd.out_sel = (status.pos == POS_FIRST) ? OUT_CENTER : OUT_RESULT;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.last)
                begin
                    cmd.out_sel = OUT_INPUT;
                    if (status.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.advance  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/topus_upwind_advection_step.sv */
// Top level of the TOPUS third-order upwind advection step, streaming form.
// Depends on tuas_pkg, tuas_ctrl and tuas_dp (which holds tuas_div, tuas_mul).
//
//  channel   dir  beat contents (lowest bit first)
//  --------  ---  --------------------------------------------------------
//  s_axis    in   tdata: old_sample (Q3.20, signed), zero pad; tlast: row_end
//  m_axis    out  tdata: new_sample (Q3.20, signed), zero pad; tlast: row_done
//  cfg       in   cfg_index 0 courant (U1.16), 1 scheme_mode; write on cfg_we
//
// One input beat at a time. A first sample of a row only updates the row state;
// a second sample emits the centre sample as the left boundary. An interior
// sample with a limited face runs the bit-serial ratio divider and then five
// passes through the shared digit-serial multiplier. A face falling back to the
// centre skips the divider and takes a single multiplier pass for the flux.
// Row end adds one beat (the last sample with row_done). Reset clears the
// row state and loads courant = 3277, scheme_mode = 1. The output register
// lets the next beat be taken while a result waits; the block only stalls
// when a second result is due and the first is still untaken.
module topus_upwind_advection_step #(
    parameter int SAMPLE_WIDTH  = tuas_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = tuas_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave side
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // old_sample
    input  logic                                    s_axis_tlast,  // row_end
    // master side
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,  // new_sample
    output logic                                    m_axis_tlast,  // row_done
    // configuration writes
    input  logic                                    cfg_we,
    input  logic [tuas_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [tuas_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import tuas_pkg::*;

    localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;

    cmd_t                    cmd;
    status_t                 status;
    logic [SAMPLE_WIDTH-1:0] out_sample;

    tuas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tuas_dp #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .in_last    (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample),
        .out_last   (m_axis_tlast)
    );

    // pad bits above the sample are zero
    assign m_axis_tdata = TDATA_WIDTH'(out_sample);

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for topus_upwind_advection_step: directed and random rows
// are streamed in, and every output beat is compared with an in-bench predictor.
// Depends on tuas_pkg and the RTL under rtl/.
module tb_top;
    import tuas_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int FB          = FRACTION_BITS_DEF;
    localparam int TDATA_W     = ((SW + 7) / 8) * 8;
    localparam int LATENCY_PAD = 120;   // margin beyond the worst interior beat
    localparam int HOLD_OFF    = 600;   // long receiver stall, in cycles
    localparam int IDLE_LIMIT  = 4000;  // watchdog: cycles with no beat accepted
    localparam int PHASE_ITEMS = 88;
    localparam int MAX_REPORTS = 40;

    typedef struct {
        logic [SW-1:0] sample;
        logic          last;
    } beat_t;

    typedef struct {
        logic [SW-1:0] sample;
        logic          done;
    } result_t;

    // DUT ports; the inputs driven by the bench are at known values from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // old_sample
    logic               s_axis_tlast = 1'b0; // row_end
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // new_sample
    logic               m_axis_tlast;        // row_done
    logic               cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    // stimulus and scoreboard
    beat_t   pending_beats[$];
    result_t due_samples[$];
    beat_t   drive_beat;
    logic    in_hs = 1'b0;        // input beat accepted at the last rising edge
    bit      sender_gaps = 1'b1;  // sender idles between bursts when set
    int      burst_left = 0;
    int      gap_left = 0;
    int      stall_epoch = 0;     // bumped by the sequencer to request a hold-off
    int      stall_seen = 0;
    int      stall_left = 0;
    int      ready_style = 0;
    int      pattern_left = 0;
    int      idle_cycles = 0;
    int      out_count = 0;
    int      mismatch_count = 0;

    // predictor copy of the registers and the row state
    logic [COURANT_WIDTH-1:0] courant_cfg = COURANT_RESET;
    logic                     scheme_cfg = MODE_RESET;
    longint                   prev_s = 0;
    longint                   prev2_s = 0;
    longint                   face_prev = 0;
    int                       row_pos = 0;

    topus_upwind_advection_step uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor(a*b / 2^k); arithmetic shift of a signed product rounds down
    function automatic longint floor_scale(input longint a, input longint b, input int k);
        return (a * b) >>> k;
    endfunction

    function automatic longint clamp_sample(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // limited face value from left, centre and right samples
    function automatic longint limited_face(input longint l, input longint c, input longint r);
        longint n;
        longint d;
        longint mn;
        longint md;
        longint u;
        longint u2;
        longint u3;
        longint u4;
        longint f;
        longint one;
        one = longint'(1) <<< FB;
        n = c - l;
        d = r - l;
        // flat neighbours or ratio outside 0..1: fall back to the centre
        if (d == 0)
            return c;
        if (d > 0 && (n < 0 || n > d))
            return c;
        if (d < 0 && (n > 0 || n < d))
            return c;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        // restoring division truncates toward zero, same as integer divide
        u  = (mn <<< FB) / md;
        u2 = floor_scale(u, u, FB);
        u3 = floor_scale(u2, u, FB);
        u4 = floor_scale(u3, u, FB);
        f  = 2 * u4 - 3 * u3 + 2 * u;
        if (f < 0)
            f = 0;
        if (f > one)
            f = one;
        return l + floor_scale(d, f, FB);
    endfunction

    // advance the row state by one accepted input beat, queue what it yields
    task automatic advect_beat(input logic [SW-1:0] raw, input logic last);
        longint  x;
        longint  l;
        longint  c;
        longint  y;
        longint  uf;
        longint  cn;
        result_t r;
        x  = longint'($signed(raw));
        cn = longint'(courant_cfg);
        if (row_pos >= 1)
        begin
            l = prev2_s;
            c = prev_s;
            if (row_pos == 1)
                y = c;  // left boundary passes through
            else
            begin
                uf = limited_face(l, c, x);
                // cell 1 (or mode 0) uses first-order upwind
                if (row_pos == 2 || scheme_cfg == 1'b0)
                    y = clamp_sample(c - floor_scale(c - l, cn, COURANT_FRAC));
                else
                    y = clamp_sample(c - floor_scale(uf - face_prev, cn, COURANT_FRAC));
                // face is tracked in both modes
                face_prev = uf;
            end
            r.sample = y[SW-1:0];
            r.done   = 1'b0;
            due_samples.push_back(r);
        end
        if (last)
        begin
            // right boundary passes through and closes the row
            r.sample = raw;
            r.done   = 1'b1;
            due_samples.push_back(r);
            prev_s    = 0;
            prev2_s   = 0;
            face_prev = 0;
            row_pos   = 0;
        end
        else
        begin
            prev2_s = prev_s;
            prev_s  = x;
            if (row_pos < 3)
                row_pos++;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("beat %0d: %s got 0x%0h want 0x%0h", out_count, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            in_hs <= 1'b0;
            idle_cycles = 0;
        end
        else
        begin
            in_hs <= s_axis_tvalid && s_axis_tready;
            // output first: a result never belongs to the beat taken this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_samples.size() == 0)
                    report_mismatch("unexpected beat", m_axis_tdata, 0);
                else
                begin
                    want = due_samples.pop_front();
                    if (m_axis_tdata[SW-1:0] !== want.sample)
                        report_mismatch("new_sample", m_axis_tdata[SW-1:0], want.sample);
                    if (m_axis_tlast !== want.done)
                        report_mismatch("row_done", m_axis_tlast, want.done);
                end
                out_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                advect_beat(s_axis_tdata[SW-1:0], s_axis_tlast);
            // watchdog on acceptance activity
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts of beats from the pending queue, random gaps between
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_hs))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                drive_beat = pending_beats.pop_front();
                s_axis_tdata  <= TDATA_W'(drive_beat.sample);
                s_axis_tlast  <= drive_beat.last;
                s_axis_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 11);
                    gap_left   = sender_gaps ? $urandom_range(1, 6) : 0;
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: changing ready patterns, plus a requested long hold-off
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_epoch != stall_seen)
        begin
            stall_seen = stall_epoch;
            stall_left = HOLD_OFF;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                ready_style  = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 96);
            end
            else
                pattern_left--;
            case (ready_style)
                0:       m_axis_tready <= 1'b1;              // no stalls
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer helpers
    // ---------------------------------------------------------------
    task automatic offer(input logic [SW-1:0] sample, input logic last);
        beat_t b;
        b.sample = sample;
        b.last   = last;
        pending_beats.push_back(b);
    endtask

    // register write at the next rising edge; only called while idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_COURANT)
            courant_cfg = value[COURANT_WIDTH-1:0];
        else
            scheme_cfg = value[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every beat is sent and every result seen, then let the block settle
    task automatic drain_results();
        while (!(pending_beats.size() == 0 && !s_axis_tvalid && due_samples.size() == 0))
            @(negedge clk);
        repeat (LATENCY_PAD) @(negedge clk);
    endtask

    // smooth ramps dominate so the limiter ratio lands inside 0..1
    function automatic logic [SW-1:0] next_sample(input logic [SW-1:0] prev, input bit rising);
        int            pick;
        logic [SW-1:0] step;
        pick = $urandom_range(0, 99);
        step = SW'($urandom_range(0, 40000));
        if (pick < 60)
            return rising ? prev + step : prev - step;
        if (pick < 75)
            return prev;                // flat neighbours
        if (pick < 90)
            return SW'($urandom);
        case ($urandom_range(0, 2))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            default: return '0;
        endcase
    endfunction

    task automatic queue_row(input int len, input bit close);
        logic [SW-1:0] s;
        bit            rising;
        rising = 1'($urandom_range(0, 1));
        s = SW'($urandom);
        for (int i = 0; i < len; i++)
        begin
            s = next_sample(s, rising);
            offer(s, close && (i == len - 1));
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence: reset, directed rows, then random phases with new settings
    // ---------------------------------------------------------------
    initial
    begin
        int  queued;
        int  len;
        int  pick;
        bit  paused;
        bit  close;
        logic [CFG_DATA_WIDTH-1:0] c_val;
        logic [7:0] mode_plan;

        mode_plan = 8'b1011_0011;   // scheme_mode per random phase, phase 0 in bit 0
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings (courant ~0.05, TOPUS)
        offer(24'h7FFFFF, 1'b1);        // one-sample row, max
        offer(24'h800000, 1'b1);        // one-sample row, min
        offer(24'd0, 1'b0);             // row start: no result
        offer(24'd100000, 1'b0);
        offer(24'd300000, 1'b0);        // ratio inside 0..1
        offer(24'd700000, 1'b0);
        offer(24'd300000, 1'b0);        // right equals left: face is centre
        offer(24'h7FFFFF, 1'b0);        // ratio below zero
        offer(24'h800000, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'h800000, 1'b0);        // flat run
        offer(-24'sd1000000, 1'b0);
        offer(24'd5, 1'b1);             // row end: pending centre then boundary
        offer(24'd500000, 1'b0);        // falling row, negative denominator
        offer(24'd400000, 1'b0);
        offer(24'd200000, 1'b0);
        offer(-24'sd100000, 1'b1);
        drain_results();

        // full Courant number, first-order upwind, extremes
        write_reg(REG_COURANT, 17'd65536);
        write_reg(REG_SCHEME_MODE, 17'd0);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'h7FFFFF, 1'b0);
        offer(24'h800000, 1'b0);
        offer(24'd0, 1'b1);
        drain_results();

        // zero Courant number, TOPUS; row left open across the next write
        write_reg(REG_COURANT, 17'd0);
        write_reg(REG_SCHEME_MODE, 17'd1);
        offer(24'd1, 1'b0);
        offer(24'd2, 1'b0);
        offer(24'd3, 1'b0);
        drain_results();

        // random phases; odd phases leave their last row open so the next
        // settings take effect mid-row
        for (int p = 0; p < 8; p++)
        begin
            if (p == 1 || p == 6)
                c_val = 17'd65536;
            else if (p == 2)
                c_val = 17'd0;
            else
                c_val = CFG_DATA_WIDTH'($urandom_range(0, 65536));
            write_reg(REG_COURANT, c_val);
            write_reg(REG_SCHEME_MODE, {16'd0, mode_plan[p]});
            sender_gaps = !(p == 4 || p == 5);
            if (p == 4)
                stall_epoch++;      // receiver holds off while beats keep coming
            queued = 0;
            paused = 1'b0;
            while (queued < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    len = 1;
                else if (pick == 1)
                    len = 2;
                else
                    len = $urandom_range(3, 18);
                close = !((p % 2 == 1) && (queued + len >= PHASE_ITEMS));
                queue_row(len, close);
                queued += len;
                if (p == 4 && !paused && queued >= PHASE_ITEMS / 2)
                begin
                    drain_results();  // sender pauses until all results are in
                    paused = 1'b1;
                end
            end
            drain_results();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/tuas_pkg.sv
rtl/tuas_div.sv
rtl/tuas_mul.sv
rtl/tuas_dp.sv
rtl/tuas_ctrl.sv
rtl/topus_upwind_advection_step.sv
tb/tb_top.sv
